>>> rtl/irdph_pkg.sv
// ----------------------------------------------------------------------------
// irdph_pkg: shared types and constants
// FNV-1 constants, symbol codes and the default frame length threshold.
// ----------------------------------------------------------------------------
package irdph_pkg;

   localparam int HASH_BITS  = 32;
   localparam int COUNT_BITS = 8;
   localparam int CSR_BITS   = 8;

   localparam logic [HASH_BITS-1:0]  HASH_PRIME = 32'd16777619;
   localparam logic [HASH_BITS-1:0]  HASH_BASIS = 32'd2166136261;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX  = 8'd255;
   localparam logic [COUNT_BITS-1:0] COUNT_FOLD = 8'd2;
   localparam logic [CSR_BITS-1:0]   MIN_DURATIONS_RESET = 8'd5;

   // comparison symbol against the same kind of duration two transfers back
   typedef enum logic [1:0] {
      SYM_SHORTER = 2'd0,
      SYM_SAME    = 2'd1,
      SYM_LONGER  = 2'd2
   } symbol_type;

endpackage

>>> rtl/irdph_if.sv
// ----------------------------------------------------------------------------
// irdph channel interfaces
// Request, response and register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface irdph_req_if #(
   parameter int DURATION_BITS = 16
);
   logic                     valid;
   logic                     ready;
   logic [DURATION_BITS-1:0] duration;
   logic                     last;

   modport source (output valid, output duration, output last, input ready);
   modport sink   (input valid, input duration, input last, output ready);
endinterface

interface irdph_rsp_if
   import irdph_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [HASH_BITS-1:0] hash;
   logic                 accepted;

   modport source (output valid, output hash, output accepted, input ready);
   modport sink   (input valid, input hash, input accepted, output ready);
endinterface

interface irdph_csr_if
   import irdph_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [CSR_BITS-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/irdph_fold.sv
// ----------------------------------------------------------------------------
// irdph_fold: duration compare and hash step
// Classifies a duration against the one two transfers back (4:5 ratio
// band either way) and folds the symbol into the running FNV-1 hash.
// ----------------------------------------------------------------------------
module irdph_fold
   import irdph_pkg::*;
#(
   parameter int DURATION_BITS = 16
) (
   input  logic [HASH_BITS-1:0]     hash_cur,
   input  logic [DURATION_BITS-1:0] older,
   input  logic [DURATION_BITS-1:0] dur,
   output logic [HASH_BITS-1:0]     hash_next
);

   localparam int PW = DURATION_BITS + 3;

   logic [PW-1:0]        older_x4;
   logic [PW-1:0]        older_x5;
   logic [PW-1:0]        dur_x4;
   logic [PW-1:0]        dur_x5;
   logic [HASH_BITS-1:0] prod;
   symbol_type           sym;

   assign older_x4 = PW'(older) << 2;
   assign older_x5 = older_x4 + PW'(older);
   assign dur_x4   = PW'(dur) << 2;
   assign dur_x5   = dur_x4 + PW'(dur);

   always_comb begin
      if (dur_x5 < older_x4) begin
         sym = SYM_SHORTER;
      end else if (older_x5 < dur_x4) begin
         sym = SYM_LONGER;
      end else begin
         sym = SYM_SAME;
      end
   end

   // multiply wraps modulo 2^32
   assign prod      = hash_cur * HASH_PRIME;
   assign hash_next = prod ^ HASH_BITS'(sym);

endmodule

>>> rtl/ir_duration_pattern_hash.sv
// ----------------------------------------------------------------------------
// ir_duration_pattern_hash: IR frame duration pattern hash
// Folds mark/space duration comparisons of one frame into an FNV-1 hash.
// ----------------------------------------------------------------------------
// a final duration passes the input register, then the response register, before rsp valid
// throughput: one duration per cycle unless a held response stalls, set by the single hash step in irdph_fold
// a held response stalls a final duration, and further durations wait behind it
// reset: synchronous, clears the frame state and any pending input and response, sets min_durations to 5
// ----------------------------------------------------------------------------
module ir_duration_pattern_hash
   import irdph_pkg::*;
#(
   parameter int DURATION_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   irdph_req_if.sink    req_if,
   irdph_rsp_if.source  rsp_if,
   irdph_csr_if.sink    csr_if
);

   // input register
   logic                     in_valid_ff;
   logic [DURATION_BITS-1:0] in_dur_ff;
   logic                     in_last_ff;

   // frame state
   logic [HASH_BITS-1:0]     hash_ff;
   logic [HASH_BITS-1:0]     hash_in;
   logic [DURATION_BITS-1:0] older_ff;
   logic [DURATION_BITS-1:0] newer_ff;
   logic [COUNT_BITS-1:0]    seen_ff;
   logic [COUNT_BITS-1:0]    seen_in;
   logic [CSR_BITS-1:0]      min_ff;

   // response register
   logic                     rsp_valid_ff;
   logic [HASH_BITS-1:0]     rsp_hash_ff;
   logic                     rsp_accepted_ff;

   logic [HASH_BITS-1:0]     hash_step;
   logic                     advance;
   logic                     frame_ok;

   irdph_fold #(
      .DURATION_BITS (DURATION_BITS)
   ) u_fold (
      .hash_cur  (hash_ff),
      .older     (older_ff),
      .dur       (in_dur_ff),
      .hash_next (hash_step)
   );

   // a final duration needs a free response register
   assign advance = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_if.ready);

   assign req_if.ready = !reset && (!in_valid_ff || advance);
   assign csr_if.ready = !reset;

   assign seen_in  = (seen_ff == COUNT_MAX) ? seen_ff : seen_ff + COUNT_BITS'(1);
   assign hash_in  = (seen_ff >= COUNT_FOLD) ? hash_step : hash_ff;
   assign frame_ok = seen_in >= min_ff;

   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.hash     = rsp_hash_ff;
   assign rsp_if.accepted = rsp_accepted_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.valid && req_if.ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         in_dur_ff  <= req_if.duration;
         in_last_ff <= req_if.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= MIN_DURATIONS_RESET;
      end else if (csr_if.valid && csr_if.ready) begin
         min_ff <= csr_if.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff  <= HASH_BASIS;
         older_ff <= '0;
         newer_ff <= '0;
         seen_ff  <= '0;
      end else if (advance) begin
         if (in_last_ff) begin
            hash_ff  <= HASH_BASIS;
            older_ff <= '0;
            newer_ff <= '0;
            seen_ff  <= '0;
         end else begin
            hash_ff  <= hash_in;
            older_ff <= newer_ff;
            newer_ff <= in_dur_ff;
            seen_ff  <= seen_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && in_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_last_ff) begin
         rsp_hash_ff     <= frame_ok ? hash_in : '0;
         rsp_accepted_ff <= frame_ok;
      end
   end

endmodule

>>> rtl/irdph_checker.sv
// ----------------------------------------------------------------------------
// irdph_checker: port-level assertions
// Watches the request and response channels of the top level over time.
// ----------------------------------------------------------------------------
module irdph_checker
   import irdph_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 req_last,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [HASH_BITS-1:0] rsp_hash,
   input logic                 rsp_accepted
);

   // a pending response holds until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hash) && $stable(rsp_accepted))
      else $error("response dropped or changed while stalled");

   // rejected frames report a zero hash
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_accepted |-> rsp_hash == '0)
      else $error("rejected frame with nonzero hash");

   // a fresh response follows a final duration transfer through the input and response registers
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_last, 2))
      else $error("response without a final duration transfer");

   // nothing is pending right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind ir_duration_pattern_hash irdph_checker u_irdph_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_if.valid),
   .req_ready    (req_if.ready),
   .req_last     (req_if.last),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .rsp_hash     (rsp_if.hash),
   .rsp_accepted (rsp_if.accepted)
);

>>> dv/ir_duration_pattern_hash_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_duration_pattern_hash_test: frame hash testbench
// Drives IR duration frames with bursty input and a stalling response side.
// A scoreboard recomputes the FNV-1 symbol hash of every frame and compares
// each response with the oldest expected one. min_durations is swept between
// frames, including its extremes and values below the reset value of five.
// ----------------------------------------------------------------------------
module ir_duration_pattern_hash_test;
   import irdph_pkg::*;

   localparam int DUR_BITS    = 16;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_ITEMS = 45;

   typedef struct {
      logic [HASH_BITS-1:0] hash;
      logic                 accepted;
   } frame_result_type;

   // ------------------------------------------------------------------------
   // frame hash scoreboard
   // ------------------------------------------------------------------------
   class frame_hash_scoreboard;
      logic [HASH_BITS-1:0]  running_hash;
      logic [DUR_BITS-1:0]   older_dur;
      logic [DUR_BITS-1:0]   newer_dur;
      logic [COUNT_BITS-1:0] seen_count;
      logic [CSR_BITS-1:0]   min_durations;
      frame_result_type      expected_q[$];
      int                    errors;

      function new();
         min_durations = MIN_DURATIONS_RESET;
         errors = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         running_hash = HASH_BASIS;
         older_dur = '0;
         newer_dur = '0;
         seen_count = '0;
      endfunction

      function void set_min_durations(logic [CSR_BITS-1:0] value);
         min_durations = value;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void note_duration(logic [DUR_BITS-1:0] dur, logic fin);
         logic [DUR_BITS+2:0] five_new, five_old, four_new, four_old;
         symbol_type          sym;
         frame_result_type    result;
         if (seen_count >= COUNT_FOLD) begin
            five_new = (DUR_BITS+3)'(dur) * (DUR_BITS+3)'(5);
            four_new = (DUR_BITS+3)'(dur) * (DUR_BITS+3)'(4);
            five_old = (DUR_BITS+3)'(older_dur) * (DUR_BITS+3)'(5);
            four_old = (DUR_BITS+3)'(older_dur) * (DUR_BITS+3)'(4);
            if (five_new < four_old) sym = SYM_SHORTER;
            else if (five_old < four_new) sym = SYM_LONGER;
            else sym = SYM_SAME;
            running_hash = (running_hash * HASH_PRIME) ^ {30'd0, sym};
         end
         older_dur = newer_dur;
         newer_dur = dur;
         if (seen_count != COUNT_MAX) seen_count++;
         if (fin) begin
            result.accepted = (seen_count >= min_durations);
            result.hash = result.accepted ? running_hash : '0;
            expected_q.push_back(result);
            clear_frame();
         end
      endfunction

      function void check_result(logic [HASH_BITS-1:0] hash, logic accepted);
         frame_result_type want;
         if (expected_q.size() == 0) begin
            $error("unexpected response: hash %h accepted %b", hash, accepted);
            errors++;
         end else begin
            want = expected_q.pop_front();
            if (hash !== want.hash) begin
               $error("hash mismatch: expected %h, actual %h", want.hash, hash);
               errors++;
            end
            if (accepted !== want.accepted) begin
               $error("accepted mismatch: expected %b, actual %b", want.accepted, accepted);
               errors++;
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   int   cycle_count = 0;
   int   burst_left = 0;
   int   sent_count = 0;

   frame_hash_scoreboard hash_sb = new();

   irdph_req_if #(.DURATION_BITS(DUR_BITS)) req_ch ();
   irdph_rsp_if rsp_ch ();
   irdph_csr_if csr_ch ();

   ir_duration_pattern_hash #(
      .DURATION_BITS(DUR_BITS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // response side: checks responses; a random stall mode is held for a random stretch, then redrawn
   initial begin
      int mode;
      int mode_left;
      mode = 0;
      mode_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready)
            hash_sb.check_result(rsp_ch.hash, rsp_ch.accepted);
         if (mode_left == 0) begin
            mode = $urandom_range(0, 3);
            mode_left = $urandom_range(16, 96);
         end
         mode_left--;
         case (mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ch.ready <= (mode_left % 5 != 0);
         endcase
      end
   end

   // one duration transfer; gaps fall between bursts of random length
   task automatic send_duration(input logic [DUR_BITS-1:0] dur, input logic fin);
      if (burst_left == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 24);
      end
      req_ch.valid <= 1'b1;
      req_ch.duration <= dur;
      req_ch.last <= fin;
      do @(posedge clock); while (!req_ch.ready);
      hash_sb.note_duration(dur, fin);
      burst_left--;
      sent_count++;
   endtask

   // style 0: raw random, 1: jittered mark/space pairs, 2: extreme values
   task automatic send_frame(input int len, input int style);
      logic [DUR_BITS-1:0] mark_base, space_base, base, dur;
      int                  pct;
      mark_base = DUR_BITS'($urandom_range(1, 48000));
      space_base = DUR_BITS'($urandom_range(1, 48000));
      for (int i = 0; i < len; i++) begin
         case (style)
            0: dur = DUR_BITS'($urandom);
            1: begin
               base = i[0] ? space_base : mark_base;
               pct = $urandom_range(65, 135);
               dur = DUR_BITS'((32'(base) * pct) / 100);
            end
            default: begin
               case ($urandom_range(0, 3))
                  0: dur = '0;
                  1: dur = '1;
                  2: dur = DUR_BITS'($urandom_range(0, 15));
                  default: dur = DUR_BITS'($urandom);
               endcase
            end
         endcase
         send_duration(dur, i == len - 1);
      end
   endtask

   task automatic drain(input int settle);
      req_ch.valid <= 1'b0;
      while (hash_sb.pending() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_min_durations(input logic [CSR_BITS-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.data <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      hash_sb.set_min_durations(value);
   endtask

   // {last, duration}: shorter/same/longer symbols, 4:5 ratio edges,
   // extremes, and frames around the reset threshold of five
   logic [DUR_BITS:0] directed_items [22] = '{
      {1'b0, 16'd100},   {1'b0, 16'd200},   {1'b0, 16'd79},
      {1'b0, 16'd200},   {1'b0, 16'd80},    {1'b0, 16'd251},
      {1'b0, 16'd99},    {1'b0, 16'd250},   {1'b1, 16'd100},
      {1'b0, 16'd5},     {1'b0, 16'd0},     {1'b0, 16'd4},
      {1'b0, 16'd0},     {1'b0, 16'd5},     {1'b1, 16'd65535},
      {1'b1, 16'd65535},
      {1'b0, 16'd0},     {1'b1, 16'd65535},
      {1'b0, 16'd0},     {1'b0, 16'd65535}, {1'b0, 16'd65535},
      {1'b1, 16'd0}
   };

   initial begin
      logic [CSR_BITS-1:0] thresholds [7];
      int                  phase_start;
      int                  pick;
      thresholds = '{8'd3, 8'd255, 8'd0, 8'd1, 8'd2, 8'd0, MIN_DURATIONS_RESET};
      thresholds[5] = CSR_BITS'($urandom_range(6, 20));
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.duration <= '0;
      req_ch.last <= 1'b0;
      csr_ch.valid <= 1'b0;
      csr_ch.data <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset threshold is in force here
      foreach (directed_items[i])
         send_duration(directed_items[i][DUR_BITS-1:0], directed_items[i][DUR_BITS]);

      foreach (thresholds[p]) begin
         drain(4);
         write_min_durations(thresholds[p]);
         // a frame past the count saturation point is accepted at 255
         if (thresholds[p] == COUNT_MAX) send_frame(300, $urandom_range(0, 2));
         phase_start = sent_count;
         while (sent_count - phase_start < PHASE_ITEMS) begin
            pick = $urandom_range(0, 9);
            send_frame(($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                   : $urandom_range(1, 12),
                       (pick < 6) ? 1 : (pick < 8) ? 0 : 2);
         end
      end

      drain(8);
      if (hash_sb.errors == 0 && hash_sb.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
